[hw/rtl/assert_macros.svh]
// assertion macros used by the debouncer top-level rtl file
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: condition must never hold");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
`else
`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/bdhr_pkg.sv]
// shared widths, register indexes and payload types of the button debouncer
// no dependencies
package bdhr_pkg;

    localparam int BTN_W  = 3;
    localparam int CNT_W  = 4;
    localparam int TIME_W = 32;
    localparam int MS_W   = 16;
    localparam int CFG_W  = 4;

    localparam logic [CFG_W-1:0] CFG_HOLD_MS   = 4'd0;
    localparam logic [CFG_W-1:0] CFG_REPEAT_MS = 4'd1;

    typedef struct packed {
        logic [BTN_W-1:0]  button;
        logic              level;
        logic [TIME_W-1:0] now;
    } t_sample;

    typedef struct packed {
        logic [BTN_W-1:0] button;
        logic             down;
        logic             press;
        logic             release_ev;
        logic             hold;
        logic             repeat_ev;
        logic [MS_W-1:0]  repeats;
    } t_result;

endpackage

[hw/rtl/button_debounce_hold_repeat_unit.sv]
// button debouncer with long-press and auto-repeat detection, top level
// depends on bdhr_pkg and assert_macros.svh
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  --------------------------------
//  sample    in         i_in_valid / o_in_stall   button index, raw level, now_ms
//  result    out        o_out_valid / i_out_stall button, state, events, count
//  config    in         i_cfg_valid / o_cfg_ready register index, write data
//
// one sample per cycle unless o_in_stall is high; a result is valid once its
// sample has passed the input register, then the result register; per-button
// state is written as the sample leaves the input register, so the next sample
// of the same button sees it; reset clears configuration and all per-button
// state; config is always ready. a stalled result holds the result register
// and, once the input register is full, stalls the sample channel as well.
`include "assert_macros.svh"

module button_debounce_hold_repeat_unit #(
    parameter int NUM_BUTTONS    = 8,
    parameter int DEBOUNCE_STEPS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bdhr_pkg::BTN_W-1:0]  i_button_index,
    input  logic                        i_raw_level,
    input  logic [bdhr_pkg::TIME_W-1:0] i_now_ms,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bdhr_pkg::BTN_W-1:0]  o_which_button,
    output logic                        o_debounced_state,
    output logic                        o_press_event,
    output logic                        o_release_event,
    output logic                        o_hold_event,
    output logic                        o_repeat_event,
    output logic [bdhr_pkg::MS_W-1:0]   o_repeat_count,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bdhr_pkg::CFG_W-1:0]  i_cfg_index,
    input  logic [bdhr_pkg::MS_W-1:0]   i_cfg_data
);
    import bdhr_pkg::*;

    // only buttons reachable by the index field need storage
    localparam int NB    = (NUM_BUTTONS < (1 << BTN_W)) ? NUM_BUTTONS : (1 << BTN_W);
    localparam int IDX_W = (NB > 1) ? $clog2(NB) : 1;
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(DEBOUNCE_STEPS);

    logic [MS_W-1:0] r_hold_ms;
    logic [MS_W-1:0] r_repeat_ms;

    logic             r_in_valid;
    t_sample          r_in;
    logic             r_out_valid;
    t_result          r_out;
    t_result          n_out;

    logic [CNT_W-1:0]  r_cnt        [NB];
    logic              r_down       [NB];
    logic [TIME_W-1:0] r_hold_start [NB];
    logic              r_hold_fired [NB];
    logic [MS_W-1:0]   r_repeats    [NB];

    logic [CNT_W-1:0]  n_cnt;
    logic              n_down;
    logic [TIME_W-1:0] n_hold_start;
    logic              n_hold_fired;
    logic [MS_W-1:0]   n_repeats;

    logic              out_free;
    logic              advance;
    logic              btn_ok;
    logic [IDX_W-1:0]  idx;
    logic              press;
    logic              release_ev;
    logic              hold;
    logic              repeat_ev;
    logic [TIME_W-1:0] elapsed;
    logic [MS_W:0]     rep_mult;
    logic [TIME_W:0]   rep_next;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign o_cfg_ready = 1'b1;

    assign btn_ok = 7'(r_in.button) < 7'(NUM_BUTTONS);
    assign idx    = r_in.button[IDX_W-1:0];

    // debounce first, then hold and repeat checks on the updated state
    assign rep_mult = {1'b0, n_repeats} + {{MS_W{1'b0}}, 1'b1};
    assign rep_next = (TIME_W+1)'(rep_mult) * (TIME_W+1)'(r_repeat_ms);
    assign elapsed  = r_in.now - n_hold_start;

    always_comb begin
        n_cnt        = r_cnt[idx];
        n_down       = r_down[idx];
        n_hold_start = r_hold_start[idx];
        n_hold_fired = r_hold_fired[idx];
        n_repeats    = r_repeats[idx];
        press        = 1'b0;
        release_ev   = 1'b0;
        if (r_in.level) begin
            if (n_cnt < STEPS) begin
                n_cnt = n_cnt + 1'b1;
                if (!n_down && n_cnt == STEPS) begin
                    n_down = 1'b1;
                    press  = 1'b1;
                    if (!n_hold_fired) begin
                        n_hold_start = r_in.now;
                    end
                end
            end
        end else begin
            if (n_cnt != '0) begin
                n_cnt = n_cnt - 1'b1;
                if (n_down && n_cnt == '0) begin
                    n_down       = 1'b0;
                    release_ev   = 1'b1;
                    n_hold_fired = 1'b0;
                    n_hold_start = r_in.now;
                    n_repeats    = '0;
                end
            end
        end
    end

    // second half reads the debounce-updated values through elapsed and rep_next
    logic              fin_hold_fired;
    logic [MS_W-1:0]   fin_repeats;

    always_comb begin
        fin_hold_fired = n_hold_fired;
        fin_repeats    = n_repeats;
        hold           = 1'b0;
        repeat_ev      = 1'b0;
        if (n_down) begin
            if (r_hold_ms != '0 && !n_hold_fired && elapsed >= TIME_W'(r_hold_ms)) begin
                fin_hold_fired = 1'b1;
                hold           = 1'b1;
            end
            if (r_repeat_ms != '0 && n_repeats != '1 && {1'b0, elapsed} >= rep_next) begin
                fin_repeats = n_repeats + 1'b1;
                repeat_ev   = 1'b1;
            end
        end
    end

    always_comb begin
        n_out        = '0;
        n_out.button = r_in.button;
        if (btn_ok) begin
            n_out.down       = n_down;
            n_out.press      = press;
            n_out.release_ev = release_ev;
            n_out.hold       = hold;
            n_out.repeat_ev  = repeat_ev;
            n_out.repeats    = fin_repeats;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ms   <= '0;
            r_repeat_ms <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HOLD_MS:   r_hold_ms   <= i_cfg_data;
                CFG_REPEAT_MS: r_repeat_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in.button <= i_button_index;
            r_in.level  <= i_raw_level;
            r_in.now    <= i_now_ms;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NB; b++) begin
                r_cnt[b]        <= '0;
                r_down[b]       <= 1'b0;
                r_hold_start[b] <= '0;
                r_hold_fired[b] <= 1'b0;
                r_repeats[b]    <= '0;
            end
        end else if (advance && btn_ok) begin
            r_cnt[idx]        <= n_cnt;
            r_down[idx]       <= n_down;
            r_hold_start[idx] <= n_hold_start;
            r_hold_fired[idx] <= fin_hold_fired;
            r_repeats[idx]    <= fin_repeats;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_which_button    = r_out.button;
    assign o_debounced_state = r_out.down;
    assign o_press_event     = r_out.press;
    assign o_release_event   = r_out.release_ev;
    assign o_hold_event      = r_out.hold;
    assign o_repeat_event    = r_out.repeat_ev;
    assign o_repeat_count    = r_out.repeats;

    `ASSERT_NEVER(a_press_and_release, i_clk, i_rst_n, r_out_valid && r_out.press && r_out.release_ev)
    `ASSERT_IMPLIES(a_event_state, i_clk, i_rst_n, r_out_valid && (r_out.press || r_out.hold), r_out.down && !r_out.release_ev)
    `ASSERT_IMPLIES(a_repeat_counted, i_clk, i_rst_n, r_out_valid && r_out.repeat_ev, r_out.down && r_out.repeats != '0)
    `ASSERT_IMPLIES(a_stall_needs_item, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)

endmodule
